// ===== design/scr_pkg.sv =====
// Shared constants, types and datapath operation codes of the sector cache tag engine.
`timescale 1ns / 1ps
`default_nettype none
package scr_pkg;

  // Cache geometry
  localparam int ENTRIES     = 64;
  localparam int SECTOR_BITS = 32;
  localparam int MAX_RESULTS = 64;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int STEP_W = $clog2(2 * ENTRIES);
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // Channel field widths
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int SECTOR_W = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_READ     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREFETCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAN    = 2'd3;

  // Datapath operations issued by the controller, one per cycle
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_ACCEPT     = 4'd1;
  localparam op_t OP_LOOK_NEXT  = 4'd2;
  localparam op_t OP_HIT        = 4'd3;
  localparam op_t OP_PICK_FREE  = 4'd4;
  localparam op_t OP_SWEEP_INIT = 4'd5;
  localparam op_t OP_SWEEP      = 4'd6;
  localparam op_t OP_FILL       = 4'd7;
  localparam op_t OP_CLEAN_TAKE = 4'd8;
  localparam op_t OP_CLEAN_SKIP = 4'd9;
  localparam op_t OP_CLEAN_END  = 4'd10;

  // Datapath status seen by the controller
  typedef struct packed {
    logic in_clean;    // offered request is a clean-all
    logic match;       // slot under the scan index holds the requested sector
    logic dirty_here;  // slot under the scan index is valid, dirty and within the result cap
    logic idx_last;    // scan index is on the last slot
    logic free_ok;     // a free slot was seen and the cache is not full
    logic victim;      // slot under the clock hand is valid and unreferenced
    logic sweep_last;  // clock sweep is on its final step
    logic pend_valid;  // a clean-all write-back is held back
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage
`default_nettype wire

// ===== design/scr_if.sv =====
// Request and response channel interfaces of the sector cache tag engine.
`timescale 1ns / 1ps
`default_nettype none
interface scr_req_if;
  import scr_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SECTOR_W-1:0] sector;
  modport source (output valid, kind, sector, input ready);
  modport sink (input valid, kind, sector, output ready);
endinterface

interface scr_rsp_if;
  import scr_pkg::*;
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic                hit;
  logic                fill;
  logic                write_back;
  logic [SECTOR_W-1:0] write_back_sector;
  logic                last;
  modport source (output valid, slot, hit, fill, write_back, write_back_sector, last,
                  input ready);
  modport sink (input valid, slot, hit, fill, write_back, write_back_sector, last,
                output ready);
endinterface
`default_nettype wire

// ===== design/sector_cache_clock_replacement_core.sv =====
// Top level of the sector cache tag engine with clock second-chance replacement.
//
//   channel  direction  transaction carries
//   req      in         kind, sector
//   rsp      out        slot, hit, fill, write_back, write_back_sector, last
//
// One request at a time. A hit waits for the one-slot-per-cycle tag RAM scan to reach its
// slot. A miss scans every slot and, when the cache is full, then moves the one-slot-per-cycle
// hand through a clock sweep of 1 to 128 steps. A clean-all scans every slot, and its last
// write-back also waits out output stalls; with no dirty slot the next request can go once
// the scan is done.
// Reset is synchronous and clears all slot flags, hand and count at once.
// A waiting result sits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module sector_cache_clock_replacement_core (
  input wire logic clk,
  input wire logic rst,
  scr_req_if.sink   req,
  scr_rsp_if.source rsp
);
  import scr_pkg::*;

  op_t     op;
  status_t status;

  scr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .op       (op)
  );

  scr_datapath u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .op                    (op),
    .status                (status),
    .in_kind               (req.kind),
    .in_sector             (req.sector),
    .out_valid             (rsp.valid),
    .out_ready             (rsp.ready),
    .out_slot              (rsp.slot),
    .out_hit               (rsp.hit),
    .out_fill              (rsp.fill),
    .out_write_back        (rsp.write_back),
    .out_write_back_sector (rsp.write_back_sector),
    .out_last              (rsp.last)
  );

endmodule
`default_nettype wire

// ===== design/scr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/scr_ctrl.sv =====
// Controller state machine: sequences lookup, free slot pick, clock sweep, fill and clean-all.
`timescale 1ns / 1ps
`default_nettype none
module scr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire scr_pkg::status_t status,
  output scr_pkg::op_t          op
);
  import scr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_CSCAN = 3'd5;
  localparam logic [2:0] S_CEND  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = status.in_clean ? S_CSCAN : S_LOOK;
        end
      end
      S_LOOK: begin
        if (status.match) begin
          if (status.out_free) begin
            op         = OP_HIT;
            state_next = S_IDLE;
          end
        end else begin
          op = OP_LOOK_NEXT;
          if (status.idx_last) begin
            state_next = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (status.free_ok) begin
          op         = OP_PICK_FREE;
          state_next = S_FILL;
        end else begin
          op         = OP_SWEEP_INIT;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        op = OP_SWEEP;
        if (status.victim || status.sweep_last) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (status.out_free) begin
          op         = OP_FILL;
          state_next = S_IDLE;
        end
      end
      S_CSCAN: begin
        if (status.dirty_here) begin
          // hold while the previous write-back cannot leave
          if (!status.pend_valid || status.out_free) begin
            op = OP_CLEAN_TAKE;
            if (status.idx_last) begin
              state_next = S_CEND;
            end
          end
        end else begin
          op = OP_CLEAN_SKIP;
          if (status.idx_last) begin
            state_next = S_CEND;
          end
        end
      end
      S_CEND: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          op         = OP_CLEAN_END;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/scr_datapath.sv =====
// Datapath: slot flags, tag RAM, clock hand, occupancy, scan index and output register.
`timescale 1ns / 1ps
`default_nettype none
module scr_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire scr_pkg::op_t                 op,
  output scr_pkg::status_t                  status,
  input  wire logic [scr_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [scr_pkg::SECTOR_W-1:0] in_sector,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [scr_pkg::SLOT_W-1:0]   out_slot,
  output logic                              out_hit,
  output logic                              out_fill,
  output logic                              out_write_back,
  output logic      [scr_pkg::SECTOR_W-1:0] out_write_back_sector,
  output logic                              out_last
);
  import scr_pkg::*;

  // Slot flags and engine state
  logic [ENTRIES-1:0]     valid;
  logic [ENTRIES-1:0]     dirty;
  logic [ENTRIES-1:0]     refd;
  logic [OCC_W-1:0]       occupancy;
  logic [IDX_W-1:0]       hand;
  logic [IDX_W-1:0]       idx;
  logic [STEP_W-1:0]      step_cnt;
  logic [CNT_W-1:0]       clean_cnt;
  logic                   free_found;
  logic                   pend_valid;

  // Request and held payload
  logic [KIND_W-1:0]      kind;
  logic [SECTOR_BITS-1:0] sector;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       pend_slot;
  logic [SECTOR_BITS-1:0] pend_tag;

  // Combinational helpers
  logic [IDX_W-1:0]       idx_next;
  logic [IDX_W-1:0]       hand_inc;
  logic [SECTOR_BITS-1:0] rd_tag;
  logic [OCC_W-1:0]       occ_mid;
  logic [OCC_W-1:0]       occ_new;
  logic                   victim;
  logic                   sweep_last;
  logic                   out_free;
  logic                   out_load;
  logic                   fill_wb;
  logic [SLOT_W-1:0]      load_slot;
  logic                   load_hit;
  logic                   load_fill;
  logic                   load_wb;
  logic [SECTOR_W-1:0]    load_wb_sector;
  logic                   load_last;

  assign hand_inc   = (hand == IDX_W'(ENTRIES - 1)) ? '0 : hand + IDX_W'(1);
  assign victim     = valid[hand] && !refd[hand];
  assign sweep_last = (step_cnt == STEP_W'(2 * ENTRIES - 1));
  assign out_free   = !out_valid || out_ready;
  assign fill_wb    = valid[idx] && dirty[idx];

  // Drop the old slot from the count, then add the new one
  assign occ_mid = (valid[idx] && (occupancy != '0)) ? occupancy - OCC_W'(1) : occupancy;
  assign occ_new = (occ_mid < OCC_W'(ENTRIES)) ? occ_mid + OCC_W'(1) : occ_mid;

  // Scan index update; the tag RAM reads at the next index so rd_tag follows idx
  always_comb begin
    case (op)
      OP_ACCEPT:     idx_next = '0;
      OP_LOOK_NEXT,
      OP_CLEAN_TAKE,
      OP_CLEAN_SKIP: idx_next = idx + IDX_W'(1);
      OP_PICK_FREE:  idx_next = free_idx;
      OP_SWEEP:      idx_next = victim ? hand : (sweep_last ? hand_inc : idx);
      default:       idx_next = idx;
    endcase
  end

  scr_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (op == OP_FILL),
    .wr_addr (idx),
    .wr_data (sector),
    .rd_addr (idx_next),
    .rd_data (rd_tag)
  );

  // Status to the controller
  always_comb begin
    status.in_clean   = (in_kind == KIND_CLEAN);
    status.match      = valid[idx] && (rd_tag == sector);
    status.dirty_here = valid[idx] && dirty[idx] && (clean_cnt != CNT_W'(MAX_RESULTS));
    status.idx_last   = (idx == IDX_W'(ENTRIES - 1));
    status.free_ok    = free_found && (occupancy < OCC_W'(ENTRIES));
    status.victim     = victim;
    status.sweep_last = sweep_last;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      dirty      <= '0;
      refd       <= '0;
      occupancy  <= '0;
      hand       <= '0;
      idx        <= '0;
      step_cnt   <= '0;
      clean_cnt  <= '0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      case (op)
        OP_ACCEPT: begin
          free_found <= 1'b0;
          pend_valid <= 1'b0;
          clean_cnt  <= '0;
        end
        OP_LOOK_NEXT: begin
          if (!valid[idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
        OP_HIT: begin
          refd[idx] <= 1'b1;
          if (kind == KIND_WRITE) begin
            dirty[idx] <= 1'b1;
          end
        end
        OP_SWEEP_INIT: begin
          step_cnt <= '0;
        end
        OP_SWEEP: begin
          // give a referenced slot its second chance and move on
          if (!victim) begin
            if (valid[hand]) begin
              refd[hand] <= 1'b0;
            end
            hand     <= hand_inc;
            step_cnt <= step_cnt + STEP_W'(1);
          end
        end
        OP_FILL: begin
          valid[idx] <= 1'b1;
          dirty[idx] <= (kind == KIND_WRITE);
          refd[idx]  <= 1'b1;
          occupancy  <= occ_new;
        end
        OP_CLEAN_TAKE: begin
          pend_valid <= 1'b1;
          dirty[idx] <= 1'b0;
          clean_cnt  <= clean_cnt + CNT_W'(1);
        end
        OP_CLEAN_END: begin
          pend_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Request and held payload
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        kind   <= in_kind;
        sector <= SECTOR_BITS'(in_sector);
      end
      OP_LOOK_NEXT: begin
        if (!valid[idx] && !free_found) begin
          free_idx <= idx;
        end
      end
      OP_CLEAN_TAKE: begin
        pend_slot <= idx;
        pend_tag  <= rd_tag;
      end
      default: begin
      end
    endcase
  end

  // Result contents for the operation that emits one
  assign out_load = (op == OP_HIT) || (op == OP_FILL) || (op == OP_CLEAN_END)
                 || ((op == OP_CLEAN_TAKE) && pend_valid);

  always_comb begin
    case (op)
      OP_HIT: begin
        load_slot      = SLOT_W'(idx);
        load_hit       = 1'b1;
        load_fill      = 1'b0;
        load_wb        = 1'b0;
        load_wb_sector = '0;
        load_last      = 1'b1;
      end
      OP_FILL: begin
        load_slot      = SLOT_W'(idx);
        load_hit       = 1'b0;
        load_fill      = 1'b1;
        load_wb        = fill_wb;
        load_wb_sector = fill_wb ? SECTOR_W'(rd_tag) : '0;
        load_last      = 1'b1;
      end
      default: begin
        load_slot      = SLOT_W'(pend_slot);
        load_hit       = 1'b0;
        load_fill      = 1'b0;
        load_wb        = 1'b1;
        load_wb_sector = SECTOR_W'(pend_tag);
        load_last      = (op == OP_CLEAN_END);
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot              <= load_slot;
      out_hit               <= load_hit;
      out_fill              <= load_fill;
      out_write_back        <= load_wb;
      out_write_back_sector <= load_wb_sector;
      out_last              <= load_last;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sector cache tag engine with clock replacement.
`timescale 1ns / 1ps
module tb;
  import scr_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SECTOR_W-1:0] sector;
    logic                drain;   // hold off until every predicted response is back
  } sector_request_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill;
    logic                write_back;
    logic [SECTOR_W-1:0] write_back_sector;
    logic                last;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scr_req_if req_ch();
  scr_rsp_if rsp_ch();

  sector_cache_clock_replacement_core uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Drive the channels from local variables so every input is known from time zero
  logic                drv_valid  = 1'b0;
  logic [KIND_W-1:0]   drv_kind   = KIND_READ;
  logic [SECTOR_W-1:0] drv_sector = '0;
  logic                drv_ready  = 1'b0;

  assign req_ch.valid  = drv_valid;
  assign req_ch.kind   = drv_kind;
  assign req_ch.sector = drv_sector;
  assign rsp_ch.ready  = drv_ready;

  sector_request_t pending_requests[$];
  slot_report_t    predicted_reports[$];

  // Shadow copy of the cache tag state
  logic                   line_valid [ENTRIES];
  logic [SECTOR_BITS-1:0] line_tag   [ENTRIES];
  logic                   line_dirty [ENTRIES];
  logic                   line_ref   [ENTRIES];
  int unsigned            hand_pos;
  int unsigned            lines_used;

  int  error_count = 0;
  logic req_fire   = 1'b0;
  logic calm       = 1'b0;
  int  cycle_count = 0;
  int  req_gap     = 0;
  int  rsp_stall   = 0;
  int  stall_len;

  initial begin
    forever #10 clk = ~clk;
  end

  // Clear the shadow state to match reset
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_dirty[i] = 1'b0;
      line_ref[i]   = 1'b0;
    end
    hand_pos   = 0;
    lines_used = 0;
  end

  // Mostly short gaps, a few long ones, none during a calm stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Predict the responses one accepted transaction causes and update the shadow state
  task automatic compute_slot_reports(input logic [KIND_W-1:0] kind,
                                      input logic [SECTOR_W-1:0] sector);
    slot_report_t rep;
    int           dirty_total;
    int           emitted;
    int           victim;
    bit           found;
    rep = '0;
    dirty_total = 0;
    emitted = 0;
    victim = 0;
    found = 1'b0;
    if (kind == KIND_CLEAN) begin
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && line_dirty[i] && dirty_total < MAX_RESULTS) dirty_total++;
      for (int i = 0; i < ENTRIES && emitted < dirty_total; i++) begin
        if (line_valid[i] && line_dirty[i]) begin
          rep.slot              = SLOT_W'(i);
          rep.write_back        = 1'b1;
          rep.write_back_sector = line_tag[i];
          rep.last              = (emitted == dirty_total - 1);
          predicted_reports.push_back(rep);
          line_dirty[i] = 1'b0;
          emitted++;
        end
      end
      return;
    end

    // Lookup: lowest matching valid slot wins
    for (int i = 0; i < ENTRIES && !found; i++) begin
      if (line_valid[i] && line_tag[i] == sector) begin
        found = 1'b1;
        line_ref[i] = 1'b1;
        if (kind == KIND_WRITE) line_dirty[i] = 1'b1;
        rep.slot = SLOT_W'(i);
        rep.hit  = 1'b1;
        rep.last = 1'b1;
        predicted_reports.push_back(rep);
      end
    end
    if (found) return;

    // Miss: lowest free slot while not full, else clock sweep
    if (lines_used < ENTRIES) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!line_valid[i]) begin
          victim = i;
          found = 1'b1;
        end
    end
    if (!found) begin
      for (int step = 0; step < 2 * ENTRIES && !found; step++) begin
        if (line_valid[hand_pos] && !line_ref[hand_pos]) begin
          found = 1'b1;
        end else begin
          if (line_valid[hand_pos]) line_ref[hand_pos] = 1'b0;
          hand_pos = (hand_pos + 1) % ENTRIES;
        end
      end
      victim = hand_pos;
    end
    if (line_valid[victim]) begin
      if (line_dirty[victim]) begin
        rep.write_back        = 1'b1;
        rep.write_back_sector = line_tag[victim];
      end
      if (lines_used > 0) lines_used--;
    end
    line_valid[victim] = 1'b1;
    line_tag[victim]   = sector;
    line_dirty[victim] = (kind == KIND_WRITE);
    line_ref[victim]   = 1'b1;
    if (lines_used < ENTRIES) lines_used++;
    rep.slot = SLOT_W'(victim);
    rep.fill = 1'b1;
    rep.last = 1'b1;
    predicted_reports.push_back(rep);
  endtask

  task automatic queue_request(input logic [KIND_W-1:0] kind,
                               input logic [SECTOR_W-1:0] sector, input logic drain);
    sector_request_t item;
    item.kind   = kind;
    item.sector = sector;
    item.drain  = drain;
    pending_requests.push_back(item);
  endtask

  task automatic report_field(input string name, input logic [SECTOR_W-1:0] exp_val,
                              input logic [SECTOR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Switch between stretches with idling and calm stretches without
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Request driver: hold the transaction until taken, then idle or offer the next one
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !req_fire) begin
      drv_valid <= 1'b1;
    end else if (req_gap > 0) begin
      drv_valid <= 1'b0;
      req_gap   <= req_gap - 1;
    end else if (pending_requests.size() > 0 &&
                 !(pending_requests[0].drain && predicted_reports.size() > 0)) begin
      drv_valid  <= 1'b1;
      drv_kind   <= pending_requests[0].kind;
      drv_sector <= pending_requests[0].sector;
      req_gap    <= pick_gap();
      void'(pending_requests.pop_front());
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // Accept side: predict on each request transaction
  always @(posedge clk) begin
    req_fire <= drv_valid && req_ch.ready && !rst;
    if (!rst && drv_valid && req_ch.ready) compute_slot_reports(drv_kind, drv_sector);
  end

  // Response ready with random stalls
  always @(negedge clk) begin
    if (rst) begin
      drv_ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      drv_ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      stall_len = pick_gap();
      if (stall_len == 0) begin
        drv_ready <= 1'b1;
      end else begin
        drv_ready <= 1'b0;
        rsp_stall <= stall_len - 1;
      end
    end
  end

  // Monitor: compare each response transaction with the oldest prediction
  always @(posedge clk) begin
    slot_report_t exp_rep;
    if (!rst && rsp_ch.valid && drv_ready) begin
      if (predicted_reports.size() == 0) begin
        $error("unexpected response: slot %0d hit %0b fill %0b write_back %0b",
               rsp_ch.slot, rsp_ch.hit, rsp_ch.fill, rsp_ch.write_back);
        error_count++;
      end else begin
        exp_rep = predicted_reports.pop_front();
        report_field("slot", SECTOR_W'(exp_rep.slot), SECTOR_W'(rsp_ch.slot));
        report_field("hit", SECTOR_W'(exp_rep.hit), SECTOR_W'(rsp_ch.hit));
        report_field("fill", SECTOR_W'(exp_rep.fill), SECTOR_W'(rsp_ch.fill));
        report_field("write_back", SECTOR_W'(exp_rep.write_back),
                     SECTOR_W'(rsp_ch.write_back));
        report_field("write_back_sector", exp_rep.write_back_sector,
                     rsp_ch.write_back_sector);
        report_field("last", SECTOR_W'(exp_rep.last), SECTOR_W'(rsp_ch.last));
      end
    end
  end

  // Stimulus, reset and end of test
  initial begin
    logic [SECTOR_W-1:0] sector_pool[128];
    int                  r;
    int                  span;
    logic [KIND_W-1:0]   acc_kind;

    // Directed: field extremes, hits and misses of each kind, clean with and without dirt
    queue_request(KIND_READ, 32'h0000_0000, 1'b0);
    queue_request(KIND_READ, 32'h0000_0000, 1'b0);
    queue_request(KIND_WRITE, 32'hFFFF_FFFF, 1'b0);
    queue_request(KIND_WRITE, 32'hFFFF_FFFF, 1'b0);
    queue_request(KIND_PREFETCH, 32'h5555_AAAA, 1'b0);
    queue_request(KIND_PREFETCH, 32'h5555_AAAA, 1'b0);
    queue_request(KIND_WRITE, 32'h0000_0000, 1'b0);
    queue_request(KIND_CLEAN, 32'hFFFF_FFFF, 1'b0);
    queue_request(KIND_CLEAN, 32'h0000_0000, 1'b0);
    queue_request(KIND_READ, 32'hAAAA_5555, 1'b0);
    queue_request(KIND_WRITE, 32'h8000_0000, 1'b0);
    queue_request(KIND_PREFETCH, 32'h0000_0001, 1'b0);
    queue_request(KIND_READ, 32'h8000_0000, 1'b0);
    queue_request(KIND_CLEAN, 32'h1234_5678, 1'b0);
    queue_request(KIND_WRITE, 32'h7FFF_FFFF, 1'b1);
    queue_request(KIND_CLEAN, 32'h0000_0000, 1'b0);

    // Random: mostly a reused working set larger than the cache, so hits and
    // clock evictions both occur, plus fresh sectors and clean-all requests
    sector_pool[0] = 32'h0000_0000;
    sector_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 128; i++) sector_pool[i] = $urandom();
    for (int i = 0; i < 420; i++) begin
      span = (i < 210) ? 72 : 128;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       acc_kind = KIND_READ;
        1:       acc_kind = KIND_WRITE;
        default: acc_kind = KIND_PREFETCH;
      endcase
      if (r < 5)
        queue_request(KIND_CLEAN, $urandom(), 1'b0);
      else if (r < 82)
        queue_request(acc_kind, sector_pool[$urandom_range(0, span - 1)], i == 200);
      else
        queue_request(acc_kind, $urandom(), i == 200);
    end

    // Reset once, then let the driver run
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() > 0 || drv_valid) @(posedge clk);
    while (predicted_reports.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (error_count == 0 && predicted_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #(64'd80_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
